/* hw/rtl/pixel_swizzle_width_convert_core_macros.svh */
// assertion macros shared by the pixel swizzle and width convert rtl
// uses the clk and rst names of the module that expands them
`ifndef PIXEL_SWIZZLE_WIDTH_CONVERT_CORE_MACROS_SVH
`define PIXEL_SWIZZLE_WIDTH_CONVERT_CORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define PSW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define PSW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/psw_pkg.sv */
// package for the pixel swizzle and width convert block
// types, selector codes and width helpers; no dependencies
`timescale 1ns / 1ps

package psw_pkg;

  localparam int unsigned COMP_W   = 32;
  localparam int unsigned LANES    = 4;
  localparam int unsigned LANE_W   = 2;
  localparam int unsigned CODE_W   = 2;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned SEL_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 3;
  localparam int unsigned BITS_W   = 6;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH = 3'd0,
    REG_DST_WIDTH = 3'd1,
    REG_SRC_COUNT = 3'd2,
    REG_DST_COUNT = 3'd3,
    REG_SWZ_RED   = 3'd4,
    REG_SWZ_GREEN = 3'd5,
    REG_SWZ_BLUE  = 3'd6,
    REG_SWZ_ALPHA = 3'd7
  } reg_idx_t;

  // swizzle selector codes
  localparam logic [SEL_W-1:0] SEL_IDENTITY   = 3'd0;
  localparam logic [SEL_W-1:0] SEL_ZERO       = 3'd1;
  localparam logic [SEL_W-1:0] SEL_ONE        = 3'd2;
  localparam logic [SEL_W-1:0] SEL_COMP_FIRST = 3'd3;
  localparam logic [SEL_W-1:0] SEL_COMP_LAST  = 3'd6;

  // width codes
  localparam logic [CODE_W-1:0] WCODE_8  = 2'd0;
  localparam logic [CODE_W-1:0] WCODE_16 = 2'd1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd4;

  typedef logic [LANES-1:0][COMP_W-1:0] comp_vec_t;

  typedef struct packed {
    logic [CODE_W-1:0]             src_width;
    logic [CODE_W-1:0]             dst_width;
    logic [COUNT_W-1:0]            src_count;
    logic [COUNT_W-1:0]            dst_count;
    logic [LANES-1:0][SEL_W-1:0]   swizzle;
  } cfg_t;

  // component width in bits; codes two and three count as 32
  function automatic logic [BITS_W-1:0] code_bits(input logic [CODE_W-1:0] code);
    logic [BITS_W-1:0] bits;
    case (code)
      WCODE_8:  bits = 6'd8;
      WCODE_16: bits = 6'd16;
      default:  bits = 6'd32;
    endcase
    return bits;
  endfunction

  function automatic logic [COMP_W-1:0] code_mask(input logic [CODE_W-1:0] code);
    logic [COMP_W-1:0] mask;
    case (code)
      WCODE_8:  mask = 32'h0000_00ff;
      WCODE_16: mask = 32'h0000_ffff;
      default:  mask = 32'hffff_ffff;
    endcase
    return mask;
  endfunction

endpackage

/* hw/rtl/psw_cfg.sv */
// configuration register file for the pixel swizzle and width convert block
// depends on psw_pkg
`timescale 1ns / 1ps

module psw_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [psw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psw_pkg::CFG_DATA_W-1:0]  cfg_data,
  output psw_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width <= psw_pkg::WCODE_8;
      cfg.dst_width <= psw_pkg::WCODE_8;
      cfg.src_count <= psw_pkg::COUNT_RESET;
      cfg.dst_count <= psw_pkg::COUNT_RESET;
      cfg.swizzle   <= '0;
    end else if (cfg_write) begin
      case (psw_pkg::reg_idx_t'(cfg_index))
        psw_pkg::REG_SRC_WIDTH: cfg.src_width  <= cfg_data[psw_pkg::CODE_W-1:0];
        psw_pkg::REG_DST_WIDTH: cfg.dst_width  <= cfg_data[psw_pkg::CODE_W-1:0];
        psw_pkg::REG_SRC_COUNT: cfg.src_count  <= cfg_data;
        psw_pkg::REG_DST_COUNT: cfg.dst_count  <= cfg_data;
        psw_pkg::REG_SWZ_RED:   cfg.swizzle[0] <= cfg_data;
        psw_pkg::REG_SWZ_GREEN: cfg.swizzle[1] <= cfg_data;
        psw_pkg::REG_SWZ_BLUE:  cfg.swizzle[2] <= cfg_data;
        psw_pkg::REG_SWZ_ALPHA: cfg.swizzle[3] <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/psw_lane.sv */
// one destination lane: swizzle select and width shift, combinational
// depends on psw_pkg
`timescale 1ns / 1ps

module psw_lane (
  input  logic [psw_pkg::LANE_W-1:0]  lane,
  input  psw_pkg::cfg_t               cfg,
  input  psw_pkg::comp_vec_t          src,
  output logic [psw_pkg::COMP_W-1:0]  result
);

  logic [psw_pkg::SEL_W-1:0]   sel;
  logic [psw_pkg::LANE_W-1:0]  idx;
  logic                        take_src;
  logic                        force_max;
  logic [psw_pkg::BITS_W-1:0]  sbits;
  logic [psw_pkg::BITS_W-1:0]  dbits;
  logic [psw_pkg::COMP_W-1:0]  dmask;
  logic [psw_pkg::COMP_W-1:0]  value;
  logic [psw_pkg::COMP_W-1:0]  shifted;

  always_comb begin
    sel       = cfg.swizzle[lane];
    idx       = lane;
    take_src  = 1'b0;
    force_max = 1'b0;
    case (sel) inside
      psw_pkg::SEL_IDENTITY: begin
        idx      = lane;
        take_src = 1'b1;
      end
      psw_pkg::SEL_ONE: force_max = 1'b1;
      [psw_pkg::SEL_COMP_FIRST:psw_pkg::SEL_COMP_LAST]: begin
        idx      = psw_pkg::LANE_W'(sel - psw_pkg::SEL_COMP_FIRST);
        take_src = 1'b1;
      end
      default: ;
    endcase
    // selection at or past the source count reads as zero
    if ({1'b0, idx} >= cfg.src_count) take_src = 1'b0;

    sbits = psw_pkg::code_bits(cfg.src_width);
    dbits = psw_pkg::code_bits(cfg.dst_width);
    dmask = psw_pkg::code_mask(cfg.dst_width);
    value = src[idx] & psw_pkg::code_mask(cfg.src_width);

    if (dbits > sbits)      shifted = value << (dbits - sbits);
    else if (dbits < sbits) shifted = value >> (sbits - dbits);
    else                    shifted = value;

    if ({1'b0, lane} >= cfg.dst_count) result = '0;
    else if (force_max)                result = dmask;
    else if (take_src)                 result = shifted & dmask;
    else                               result = '0;
  end

endmodule

/* hw/rtl/pixel_swizzle_width_convert_core.sv */
// Pixel swizzle and component width converter. Each beat on the input side
// carries one pixel of up to four source components (8, 16 or 32 bits, in
// the low bits of in_comp0..3); each beat on the output side carries one
// destination pixel of up to four components at the destination width, with
// zeros above. Per destination lane a swizzle selector picks its own position,
// a given source component, zero, or the destination maximum; selections past
// src_count give zero and lanes past dst_count give zero. Widening shifts left,
// narrowing shifts right. The block sustains one pixel per clock while out_stall
// is low: a pixel is captured in an input register, goes through the lane muxes
// and shifters, and lands in the output register when that register is free.
// in_stall rises only when both registers hold a pixel and out_stall is high.
// Configuration is written through cfg_write/cfg_index/cfg_data and should
// change only while no pixel is in flight. Depends on psw_pkg, psw_cfg,
// psw_lane and the macro header.
`timescale 1ns / 1ps
`include "pixel_swizzle_width_convert_core_macros.svh"

module pixel_swizzle_width_convert_core (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_write,
  input  logic [psw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psw_pkg::CFG_DATA_W-1:0]  cfg_data,
  // source pixel beats
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [psw_pkg::COMP_W-1:0]      in_comp0,
  input  logic [psw_pkg::COMP_W-1:0]      in_comp1,
  input  logic [psw_pkg::COMP_W-1:0]      in_comp2,
  input  logic [psw_pkg::COMP_W-1:0]      in_comp3,
  // destination pixel beats
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [psw_pkg::COMP_W-1:0]      out_comp0,
  output logic [psw_pkg::COMP_W-1:0]      out_comp1,
  output logic [psw_pkg::COMP_W-1:0]      out_comp2,
  output logic [psw_pkg::COMP_W-1:0]      out_comp3
);

  psw_pkg::cfg_t       cfg;
  psw_pkg::comp_vec_t  src;
  psw_pkg::comp_vec_t  lane_result;
  psw_pkg::comp_vec_t  dst;
  logic                src_valid;
  logic                out_open;
  logic                in_take;

  // register file
  psw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // output register can load when empty or being drained this cycle
  assign out_open = !out_valid || !out_stall;
  // input register can load when empty or moving forward
  assign in_stall = src_valid && !out_open;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else if (!src_valid || out_open) begin
      src_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      src <= {in_comp3, in_comp2, in_comp1, in_comp0};
    end
  end

  // one converter per destination lane
  for (genvar g = 0; g < psw_pkg::LANES; g++) begin : g_lane
    psw_lane u_lane (
      .lane   (psw_pkg::LANE_W'(g)),
      .cfg    (cfg),
      .src    (src),
      .result (lane_result[g])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_open) begin
      out_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open && src_valid) begin
      dst <= lane_result;
    end
  end

  assign out_comp0 = dst[0];
  assign out_comp1 = dst[1];
  assign out_comp2 = dst[2];
  assign out_comp3 = dst[3];

  // a beat taken at the input always sits in the input register next cycle
  `PSW_ASSERT_NEXT(a_take_lands, in_take, src_valid, "accepted beat missing from input register")
  // a held pixel with a free output register must move forward
  `PSW_ASSERT_NEXT(a_moves_fwd, src_valid && !out_valid, out_valid, "pixel did not reach output register")
  // back pressure only when both registers are occupied
  `PSW_ASSERT_NOW(a_stall_full, in_stall, src_valid && out_valid && out_stall, "input stalled with room free")

endmodule
